[src/maze_dfs_backtracker_core_assert.svh]
// Assertion macros shared by the maze carver RTL.
`ifndef MAZE_DFS_BACKTRACKER_CORE_ASSERT_SVH
`define MAZE_DFS_BACKTRACKER_CORE_ASSERT_SVH

// Same-cycle implication, disabled in reset.
`define MDFS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("maze carver check failed");

// Next-cycle implication, disabled in reset.
`define MDFS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("maze carver check failed");

`endif

[src/mdfs_pkg.sv]
// Types, codes and helper functions of the maze carver.
package mdfs_pkg;

  typedef enum logic [1:0] {
    MODE_START = 2'd0,
    MODE_STEP  = 2'd1,
    MODE_READ  = 2'd2,
    MODE_CARVE = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    DIR_N = 2'd0,
    DIR_E = 2'd1,
    DIR_S = 2'd2,
    DIR_W = 2'd3
  } dir_t;

  localparam logic [7:0] ALL_WALLS   = 8'hFF;
  localparam logic [8:0] VISITED_BIT = 9'h100;
  localparam logic [4:0] SIDE_RESET  = 5'd16;
  localparam logic [4:0] SIDE_MIN    = 5'd2;
  localparam int         COORD_MAX   = 16;

  typedef struct packed {
    logic [1:0] mode;
    logic [3:0] cell_x;
    logic [3:0] cell_y;
    logic [1:0] random_dir;
  } in_item_t;

  typedef struct packed {
    logic [3:0] pos_x;
    logic [3:0] pos_y;
    logic [7:0] cell_walls;
    logic       cell_visited;
    logic       moved;
    logic       backtracked;
    logic       finished;
    logic [8:0] stack_depth;
  } out_item_t;

  typedef logic [4:0] side_t;

  typedef struct packed {
    logic       valid;
    logic [3:0] x;
    logic [3:0] y;
  } nb_t;

  function automatic logic in_grid(logic [3:0] x, logic [3:0] y, side_t side);
    return ({1'b0, x} < side) && ({1'b0, y} < side);
  endfunction

  function automatic nb_t nb_of(logic [3:0] x, logic [3:0] y, dir_t d, side_t side);
    nb_t        r;
    logic [4:0] nx;
    logic [4:0] ny;
    r.valid = 1'b1;
    nx = {1'b0, x};
    ny = {1'b0, y};
    case (d)
      DIR_N: begin
        if (y == 4'd0) r.valid = 1'b0;
        else ny = ny - 5'd1;
      end
      DIR_E: nx = nx + 5'd1;
      DIR_S: ny = ny + 5'd1;
      DIR_W: begin
        if (x == 4'd0) r.valid = 1'b0;
        else nx = nx - 5'd1;
      end
      default: r.valid = 1'b0;
    endcase
    if (nx >= side || ny >= side) r.valid = 1'b0;
    r.x = nx[3:0];
    r.y = ny[3:0];
    return r;
  endfunction

  function automatic dir_t pick_dir(logic [3:0] mask, dir_t start);
    dir_t d;
    logic found;
    d = start;
    found = 1'b0;
    for (int i = 0; i < 4; i++) begin
      if (!found) begin
        if (mask[d]) found = 1'b1;
        else d = dir_t'(2'(d) + 2'd1);
      end
    end
    return d;
  endfunction

  function automatic dir_t opposite(dir_t d);
    return dir_t'(2'(d) + 2'd2);
  endfunction

  function automatic logic [7:0] wall_mask(dir_t d);
    return 8'b11 << {d, 1'b0};
  endfunction

endpackage

[src/mdfs_chan_if.sv]
// Valid/ready channel carrying one payload per transfer.
interface mdfs_chan_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source(output valid, output data, input ready);
  modport sink(input valid, input data, output ready);
endinterface

[src/maze_dfs_backtracker_core.sv]
// Maze carver top level: sequencer, cell memory, backtrack stack and result register.
`include "maze_dfs_backtracker_core_assert.svh"

// Depth-first maze carver. One item is taken at a time; req.ready is high only
// while the sequencer is idle. All cell traffic goes through one single-port
// cell memory with registered read data, so every wall update is a
// read-modify-write. A step marks the walker cell, probes up to four
// neighbours, then opens two walls or pops the backtrack stack, and fetches the
// report cell; a report cell outside the grid skips the fetch. A start runs the
// clearing sweep of the cell memory. After reset the same sweep runs before the
// first transfer is taken; configuration writes are taken at any time. The result
// register frees the sequencer as soon as a result is loaded.
module maze_dfs_backtracker_core #(
  parameter int MAX_SIDE    = 16,
  parameter int STACK_DEPTH = 256
) (
  input logic         clk,
  input logic         rst,
  mdfs_chan_if.sink   req,
  mdfs_chan_if.source rsp,
  mdfs_chan_if.sink   cfg
);
  import mdfs_pkg::*;

  localparam int CELLS    = MAX_SIDE * MAX_SIDE;
  localparam int AW       = $clog2(CELLS);
  localparam int IW       = AW + 5;
  localparam int SW       = $clog2(STACK_DEPTH);
  localparam int SPW      = $clog2(STACK_DEPTH + 1);
  localparam int SIDE_CAP = (MAX_SIDE < COORD_MAX) ? MAX_SIDE : COORD_MAX;

  typedef enum logic [3:0] {
    S_IDLE, S_CLEAR, S_HERE_RD, S_HERE_WR, S_NB_RD, S_NB_CHK, S_DECIDE,
    S_POP_RD, S_POP_WAIT, S_THERE_RD, S_THERE_WR, S_REP_RD, S_REP_WAIT, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    PH_MARK,
    PH_OPEN,
    PH_CARVE
  } phase_t;

  function automatic logic [AW-1:0] cell_addr(logic [3:0] x, logic [3:0] y);
    logic [IW-1:0] a;
    a = IW'(y) * IW'(MAX_SIDE) + IW'(x);
    return a[AW-1:0];
  endfunction

  state_t           state;
  phase_t           phase;
  mode_t            mode;
  dir_t             rdir;
  dir_t             scan_dir;
  dir_t             cut_dir;
  side_t            grid_side;
  side_t            side;
  logic [3:0]       cx;
  logic [3:0]       cy;
  logic [3:0]       walker_x;
  logic [3:0]       walker_y;
  logic [3:0]       here_x;
  logic [3:0]       here_y;
  logic [3:0]       there_x;
  logic [3:0]       there_y;
  logic [SPW-1:0]   sp;
  logic             done_flag;
  logic             moved;
  logic             backtracked;
  logic [3:0]       free_mask;
  logic [AW-1:0]    clr_addr;
  logic             clr_mark;
  logic [7:0]       rep_walls;
  logic             rep_vis;
  logic             rsp_valid;
  out_item_t        rsp_data;

  logic [8:0]       cell_mem [CELLS];
  logic [8:0]       cell_rdata;
  logic [AW-1:0]    mem_addr;
  logic             mem_we;
  logic [8:0]       mem_wdata;
  logic [7:0]       path_stack [STACK_DEPTH];
  logic [7:0]       stack_rdata;
  logic             push;

  nb_t              scan_nb;
  nb_t              dec_nb;
  nb_t              carve_nb;
  dir_t             pick;
  logic [3:0]       rep_x;
  logic [3:0]       rep_y;
  logic [3:0]       start_x;
  logic [3:0]       start_y;
  logic [8:0]       here_wdata;
  logic [8:0]       there_wdata;

  assign req.ready = (state == S_IDLE);
  assign cfg.ready = 1'b1;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

  always_comb begin
    if (grid_side < SIDE_MIN) side = SIDE_MIN;
    else if (grid_side > 5'(SIDE_CAP)) side = 5'(SIDE_CAP);
    else side = grid_side;
  end

  assign scan_nb  = nb_of(walker_x, walker_y, scan_dir, side);
  assign pick     = pick_dir(free_mask, rdir);
  assign dec_nb   = nb_of(walker_x, walker_y, pick, side);
  assign carve_nb = nb_of(req.data.cell_x, req.data.cell_y, dir_t'(req.data.random_dir), side);
  assign rep_x    = (mode == MODE_READ) ? cx : walker_x;
  assign rep_y    = (mode == MODE_READ) ? cy : walker_y;
  assign start_x  = ({1'b0, req.data.cell_x} < side) ? req.data.cell_x : 4'(side - 5'd1);
  assign start_y  = ({1'b0, req.data.cell_y} < side) ? req.data.cell_y : 4'(side - 5'd1);
  assign push     = (state == S_DECIDE) && (free_mask != 4'd0) && (sp < SPW'(STACK_DEPTH));

  always_comb begin
    case (phase)
      PH_MARK: here_wdata = cell_rdata | VISITED_BIT;
      default: here_wdata = cell_rdata & ~{1'b0, wall_mask(cut_dir)};
    endcase
    there_wdata = cell_rdata & ~{1'b0, wall_mask(opposite(cut_dir))};
    if (phase == PH_OPEN) there_wdata = there_wdata | VISITED_BIT;
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = cell_addr(here_x, here_y);
    mem_wdata = here_wdata;
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr;
        mem_wdata = (clr_mark && clr_addr == cell_addr(walker_x, walker_y))
                    ? (VISITED_BIT | {1'b0, ALL_WALLS}) : {1'b0, ALL_WALLS};
      end
      S_HERE_WR: mem_we = 1'b1;
      S_NB_RD: mem_addr = cell_addr(scan_nb.x, scan_nb.y);
      S_THERE_RD: mem_addr = cell_addr(there_x, there_y);
      S_THERE_WR: begin
        mem_we    = 1'b1;
        mem_addr  = cell_addr(there_x, there_y);
        mem_wdata = there_wdata;
      end
      S_REP_RD: mem_addr = cell_addr(rep_x, rep_y);
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) cell_mem[mem_addr] <= mem_wdata;
    else cell_rdata <= cell_mem[mem_addr];
  end

  always_ff @(posedge clk) begin
    if (push) path_stack[sp[SW-1:0]] <= {walker_y, walker_x};
    stack_rdata <= path_stack[sp[SW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLEAR;
      phase     <= PH_MARK;
      grid_side <= SIDE_RESET;
      walker_x  <= '0;
      walker_y  <= '0;
      sp        <= '0;
      done_flag <= 1'b0;
      clr_addr  <= '0;
      clr_mark  <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) grid_side <= cfg.data;
      if (rsp_valid && rsp.ready && state != S_OUT) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (req.valid) begin
            mode        <= mode_t'(req.data.mode);
            cx          <= req.data.cell_x;
            cy          <= req.data.cell_y;
            rdir        <= dir_t'(req.data.random_dir);
            moved       <= 1'b0;
            backtracked <= 1'b0;
            free_mask   <= '0;
            case (mode_t'(req.data.mode))
              MODE_START: begin
                walker_x  <= start_x;
                walker_y  <= start_y;
                sp        <= '0;
                done_flag <= 1'b0;
                clr_addr  <= '0;
                clr_mark  <= 1'b1;
                state     <= S_CLEAR;
              end
              MODE_STEP: begin
                here_x <= walker_x;
                here_y <= walker_y;
                phase  <= PH_MARK;
                state  <= in_grid(walker_x, walker_y, side) ? S_HERE_RD : S_DECIDE;
              end
              MODE_CARVE: begin
                here_x  <= req.data.cell_x;
                here_y  <= req.data.cell_y;
                there_x <= carve_nb.x;
                there_y <= carve_nb.y;
                cut_dir <= dir_t'(req.data.random_dir);
                phase   <= PH_CARVE;
                state   <= (in_grid(req.data.cell_x, req.data.cell_y, side) && carve_nb.valid)
                           ? S_HERE_RD : S_REP_RD;
              end
              default: state <= S_REP_RD;
            endcase
          end
        end
        S_CLEAR: begin
          clr_addr <= clr_addr + AW'(1);
          if (clr_addr == AW'(CELLS - 1)) state <= clr_mark ? S_REP_RD : S_IDLE;
        end
        S_HERE_RD: state <= S_HERE_WR;
        S_HERE_WR: begin
          if (phase == PH_MARK) begin
            scan_dir <= DIR_N;
            state    <= S_NB_RD;
          end else begin
            if (phase == PH_CARVE) moved <= |(cell_rdata[7:0] & wall_mask(cut_dir));
            state <= S_THERE_RD;
          end
        end
        S_NB_RD: begin
          if (scan_nb.valid) state <= S_NB_CHK;
          else if (scan_dir == DIR_W) state <= S_DECIDE;
          else scan_dir <= dir_t'(2'(scan_dir) + 2'd1);
        end
        S_NB_CHK: begin
          free_mask[scan_dir] <= ~cell_rdata[8];
          if (scan_dir == DIR_W) begin
            state <= S_DECIDE;
          end else begin
            scan_dir <= dir_t'(2'(scan_dir) + 2'd1);
            state    <= S_NB_RD;
          end
        end
        S_DECIDE: begin
          if (free_mask != 4'd0) begin
            if (push) sp <= sp + SPW'(1);
            cut_dir   <= pick;
            here_x    <= walker_x;
            here_y    <= walker_y;
            there_x   <= dec_nb.x;
            there_y   <= dec_nb.y;
            phase     <= PH_OPEN;
            moved     <= 1'b1;
            done_flag <= 1'b0;
            state     <= S_HERE_RD;
          end else if (sp != '0) begin
            sp          <= sp - SPW'(1);
            backtracked <= 1'b1;
            state       <= S_POP_RD;
          end else begin
            done_flag <= 1'b1;
            state     <= S_REP_RD;
          end
        end
        S_POP_RD: state <= S_POP_WAIT;
        S_POP_WAIT: begin
          walker_x <= stack_rdata[3:0];
          walker_y <= stack_rdata[7:4];
          state    <= S_REP_RD;
        end
        S_THERE_RD: state <= S_THERE_WR;
        S_THERE_WR: begin
          if (phase == PH_OPEN) begin
            walker_x <= there_x;
            walker_y <= there_y;
          end
          state <= S_REP_RD;
        end
        S_REP_RD: begin
          if (in_grid(rep_x, rep_y, side)) begin
            state <= S_REP_WAIT;
          end else begin
            rep_walls <= ALL_WALLS;
            rep_vis   <= 1'b0;
            state     <= S_OUT;
          end
        end
        S_REP_WAIT: begin
          rep_walls <= cell_rdata[7:0];
          rep_vis   <= cell_rdata[8];
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!rsp_valid || rsp.ready) begin
            rsp_data.pos_x        <= walker_x;
            rsp_data.pos_y        <= walker_y;
            rsp_data.cell_walls   <= rep_walls;
            rsp_data.cell_visited <= rep_vis;
            rsp_data.moved        <= moved;
            rsp_data.backtracked  <= backtracked;
            rsp_data.finished     <= done_flag;
            rsp_data.stack_depth  <= 9'(sp);
            rsp_valid             <= 1'b1;
            state                 <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `MDFS_ASSERT_NEXT(a_busy_after_transfer, clk, rst, req.valid && req.ready, !req.ready)
  `MDFS_ASSERT_NOW(a_move_or_pop, clk, rst, rsp.valid, !(rsp.data.moved && rsp.data.backtracked))
  `MDFS_ASSERT_NOW(a_done_empty, clk, rst, rsp.valid && rsp.data.finished, rsp.data.stack_depth == 9'd0)
  `MDFS_ASSERT_NOW(a_stack_bound, clk, rst, 1'b1, sp <= SPW'(STACK_DEPTH))

endmodule

[dv/testbench.sv]
// Testbench for the maze carver: directed and random command streams checked against a behavioral model.
module testbench;
  import mdfs_pkg::*;

  localparam int STACK_SLOTS    = 256;
  localparam int LONG_HOLD      = 400;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int TAIL_CYCLES    = 300;

  logic clk;
  logic rst;

  mdfs_chan_if #(.T(in_item_t))  req_if ();
  mdfs_chan_if #(.T(out_item_t)) rsp_if ();
  mdfs_chan_if #(.T(side_t))     cfg_if ();

  maze_dfs_backtracker_core dut (
    .clk(clk),
    .rst(rst),
    .req(req_if),
    .rsp(rsp_if),
    .cfg(cfg_if)
  );

  // behavioral copy of the maze state
  logic [8:0] m_cells [0:255];
  logic [7:0] m_stack [0:STACK_SLOTS-1];
  logic [3:0] m_wx;
  logic [3:0] m_wy;
  logic [8:0] m_sp;
  logic       m_done;
  side_t      m_side;

  out_item_t pending_reports[$];

  int unsigned fails;
  int unsigned items_sent;
  int unsigned reports_checked;
  int unsigned side_writes;
  int unsigned mazes_done;
  int unsigned walks;
  int unsigned idle_cycles;
  int unsigned holds_done;
  bit          calm;
  bit          long_hold_req;
  bit          hold_active;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  function automatic logic [4:0] live_side();
    if (m_side < SIDE_MIN) return SIDE_MIN;
    if (m_side > 5'(COORD_MAX)) return 5'(COORD_MAX);
    return m_side;
  endfunction

  function automatic bit on_board(logic [3:0] x, logic [3:0] y, logic [4:0] side);
    return ({1'b0, x} < side) && ({1'b0, y} < side);
  endfunction

  function automatic bit step_to(logic [3:0] x, logic [3:0] y, logic [1:0] d,
                                 logic [4:0] side, output logic [3:0] nx,
                                 output logic [3:0] ny);
    logic [4:0] tx;
    logic [4:0] ty;
    tx = {1'b0, x};
    ty = {1'b0, y};
    nx = x;
    ny = y;
    case (d)
      DIR_N: begin
        if (y == 4'd0) return 1'b0;
        ty = ty - 5'd1;
      end
      DIR_E: tx = tx + 5'd1;
      DIR_S: ty = ty + 5'd1;
      default: begin
        if (x == 4'd0) return 1'b0;
        tx = tx - 5'd1;
      end
    endcase
    nx = tx[3:0];
    ny = ty[3:0];
    return (tx < side) && (ty < side);
  endfunction

  function automatic void open_walls(logic [3:0] x, logic [3:0] y, logic [3:0] nx,
                                     logic [3:0] ny, logic [1:0] d);
    logic [1:0] back;
    back = d + 2'd2;
    m_cells[{y, x}]   = m_cells[{y, x}] & ~(9'd3 << {d, 1'b0});
    m_cells[{ny, nx}] = m_cells[{ny, nx}] & ~(9'd3 << {back, 1'b0});
  endfunction

  function automatic void reset_maze();
    for (int i = 0; i < 256; i++) m_cells[i] = 9'(ALL_WALLS);
    for (int i = 0; i < STACK_SLOTS; i++) m_stack[i] = '0;
    m_wx = '0;
    m_wy = '0;
    m_sp = '0;
    m_done = 1'b0;
    m_side = SIDE_RESET;
  endfunction

  function automatic out_item_t advance_maze(in_item_t it);
    out_item_t  r;
    logic [4:0] side;
    logic [3:0] nx;
    logic [3:0] ny;
    logic [3:0] rx;
    logic [3:0] ry;
    logic [3:0] free;
    logic [1:0] d;
    logic [8:0] c;
    bit         ok;
    side = live_side();
    r = '0;
    case (it.mode)
      MODE_START: begin
        for (int i = 0; i < 256; i++) m_cells[i] = 9'(ALL_WALLS);
        m_wx = ({1'b0, it.cell_x} < side) ? it.cell_x : 4'(side - 5'd1);
        m_wy = ({1'b0, it.cell_y} < side) ? it.cell_y : 4'(side - 5'd1);
        m_cells[{m_wy, m_wx}][8] = 1'b1;
        m_sp = '0;
        m_done = 1'b0;
      end
      MODE_STEP: begin
        free = '0;
        if (on_board(m_wx, m_wy, side)) begin
          m_cells[{m_wy, m_wx}][8] = 1'b1;
          for (int i = 0; i < 4; i++) begin
            ok = step_to(m_wx, m_wy, 2'(i), side, nx, ny);
            if (ok && !m_cells[{ny, nx}][8]) free[i] = 1'b1;
          end
        end
        if (free != '0) begin
          if (m_sp < 9'(STACK_SLOTS)) begin
            m_stack[m_sp[7:0]] = {m_wy, m_wx};
            m_sp = m_sp + 9'd1;
          end
          d = it.random_dir;
          for (int i = 0; i < 4 && !free[d]; i++) d = d + 2'd1;
          ok = step_to(m_wx, m_wy, d, side, nx, ny);
          open_walls(m_wx, m_wy, nx, ny, d);
          m_cells[{ny, nx}][8] = 1'b1;
          m_wx = nx;
          m_wy = ny;
          r.moved = 1'b1;
          m_done = 1'b0;
        end else if (m_sp != '0) begin
          m_sp = m_sp - 9'd1;
          {m_wy, m_wx} = m_stack[m_sp[7:0]];
          r.backtracked = 1'b1;
        end else begin
          if (!m_done) mazes_done++;
          m_done = 1'b1;
        end
      end
      MODE_CARVE: begin
        if (on_board(it.cell_x, it.cell_y, side)) begin
          ok = step_to(it.cell_x, it.cell_y, it.random_dir, side, nx, ny);
          if (ok) begin
            if ((m_cells[{it.cell_y, it.cell_x}] & (9'd3 << {it.random_dir, 1'b0})) != '0)
              r.moved = 1'b1;
            open_walls(it.cell_x, it.cell_y, nx, ny, it.random_dir);
          end
        end
      end
      default: ;
    endcase
    if (it.mode == MODE_READ) begin
      rx = it.cell_x;
      ry = it.cell_y;
    end else begin
      rx = m_wx;
      ry = m_wy;
    end
    r.cell_walls = ALL_WALLS;
    r.cell_visited = 1'b0;
    if (on_board(rx, ry, side)) begin
      c = m_cells[{ry, rx}];
      r.cell_walls = c[7:0];
      r.cell_visited = c[8];
    end
    r.pos_x = m_wx;
    r.pos_y = m_wy;
    r.finished = m_done;
    r.stack_depth = m_sp;
    return r;
  endfunction

  function automatic in_item_t mk_cmd(logic [1:0] mode, logic [3:0] x, logic [3:0] y,
                                      logic [1:0] d);
    in_item_t it;
    it.mode = mode;
    it.cell_x = x;
    it.cell_y = y;
    it.random_dir = d;
    return it;
  endfunction

  function automatic in_item_t any_cmd(logic [1:0] mode);
    return mk_cmd(mode, 4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)),
                  2'($urandom_range(0, 3)));
  endfunction

  function automatic int unsigned draw_gap();
    int unsigned r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(30, 90);
  endfunction

  function automatic side_t pick_side();
    int unsigned r;
    r = $urandom_range(0, 19);
    if (r < 12) return side_t'($urandom_range(2, 5));
    if (r < 15) return side_t'($urandom_range(6, 9));
    if (r == 15) return side_t'(0);
    if (r == 16) return side_t'(1);
    if (r == 17) return side_t'($urandom_range(17, 31));
    if (r == 18) return side_t'(16);
    return side_t'($urandom_range(10, 15));
  endfunction

  function automatic void check_field(string name, logic [8:0] want, logic [8:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fails++;
    end
  endfunction

  task automatic send_cmd(in_item_t it);
    int unsigned gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap != 0) begin
      req_if.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    pending_reports.push_back(advance_maze(it));
    items_sent++;
  endtask

  task automatic wait_idle();
    @(negedge clk);
    req_if.valid <= 1'b0;
    while (pending_reports.size() != 0) @(posedge clk);
  endtask

  task automatic write_side(side_t v);
    wait_idle();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data <= v;
    @(posedge clk);
    while (!cfg_if.ready) @(posedge clk);
    m_side = v;
    side_writes++;
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  task automatic test_reset_state();
    send_cmd(mk_cmd(MODE_READ, 4'd0, 4'd0, DIR_N));
    send_cmd(mk_cmd(MODE_READ, 4'd15, 4'd15, DIR_W));
    send_cmd(mk_cmd(MODE_STEP, 4'd0, 4'd0, DIR_N));
    send_cmd(mk_cmd(MODE_STEP, 4'd15, 4'd15, DIR_W));
    send_cmd(mk_cmd(MODE_CARVE, 4'd2, 4'd0, DIR_S));
    send_cmd(mk_cmd(MODE_CARVE, 4'd2, 4'd0, DIR_S));
    send_cmd(mk_cmd(MODE_CARVE, 4'd0, 4'd0, DIR_N));
    send_cmd(mk_cmd(MODE_CARVE, 4'd15, 4'd3, DIR_E));
  endtask

  task automatic test_side_extremes();
    write_side(5'd31);
    send_cmd(mk_cmd(MODE_START, 4'd15, 4'd15, DIR_N));
    send_cmd(mk_cmd(MODE_STEP, 4'd0, 4'd0, DIR_E));
    send_cmd(mk_cmd(MODE_STEP, 4'd0, 4'd0, DIR_S));
    // shrink under the walker: it is left outside the grid
    write_side(5'd0);
    send_cmd(mk_cmd(MODE_READ, 4'd1, 4'd1, DIR_N));
    send_cmd(mk_cmd(MODE_READ, 4'd9, 4'd0, DIR_N));
    repeat (3) send_cmd(mk_cmd(MODE_STEP, 4'd0, 4'd0, DIR_N));
    send_cmd(mk_cmd(MODE_STEP, 4'd0, 4'd0, DIR_E));
    send_cmd(mk_cmd(MODE_CARVE, 4'd5, 4'd5, DIR_S));
    send_cmd(mk_cmd(MODE_START, 4'd9, 4'd12, DIR_E));
    send_cmd(mk_cmd(MODE_CARVE, 4'd1, 4'd1, DIR_S));
    send_cmd(mk_cmd(MODE_STEP, 4'd0, 4'd0, DIR_W));
    send_cmd(mk_cmd(MODE_STEP, 4'd0, 4'd0, DIR_N));
    send_cmd(mk_cmd(MODE_STEP, 4'd0, 4'd0, DIR_S));
    write_side(5'd16);
  endtask

  task automatic test_backpressure();
    write_side(5'd5);
    send_cmd(any_cmd(MODE_START));
    long_hold_req = 1'b1;
    wait (hold_active);
    repeat (12) send_cmd(any_cmd(MODE_STEP));
    wait_idle();
    calm = 1'b1;
    repeat (60) begin
      if ($urandom_range(0, 19) == 0) send_cmd(any_cmd(MODE_START));
      else send_cmd(any_cmd(MODE_STEP));
    end
    calm = 1'b0;
    wait_idle();
  endtask

  task automatic test_full_walks(int unsigned budget);
    int unsigned stop_at;
    int unsigned cap;
    int unsigned n;
    int unsigned r;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      write_side(pick_side());
      send_cmd(any_cmd(MODE_START));
      walks++;
      cap = (live_side() > 5'd8) ? $urandom_range(40, 120) : 600;
      n = 0;
      while (!m_done && n < cap) begin
        r = $urandom_range(0, 99);
        if (r < 6) send_cmd(any_cmd(MODE_READ));
        else if (r < 11) send_cmd(any_cmd(MODE_CARVE));
        else if (r == 11) send_cmd(any_cmd(MODE_START));
        else send_cmd(any_cmd(MODE_STEP));
        n++;
      end
      if (m_done && $urandom_range(0, 1) == 0) send_cmd(any_cmd(MODE_STEP));
    end
  endtask

  task automatic test_noise(int unsigned budget);
    int unsigned stop_at;
    stop_at = items_sent + budget;
    while (items_sent < stop_at) begin
      write_side(side_t'($urandom_range(0, 31)));
      repeat ($urandom_range(15, 40)) send_cmd(any_cmd(2'($urandom_range(0, 3))));
    end
  endtask

  initial begin : rsp_ready_proc
    int unsigned hold_left;
    int unsigned gap_left;
    hold_left = 0;
    gap_left = 0;
    rsp_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req && hold_left == 0) begin
        long_hold_req = 1'b0;
        hold_left = LONG_HOLD;
        hold_active = 1'b1;
      end
      if (hold_left != 0) begin
        rsp_if.ready <= 1'b0;
        hold_left--;
        if (hold_left == 0) begin
          hold_active = 1'b0;
          holds_done++;
        end
      end else if (gap_left != 0) begin
        rsp_if.ready <= 1'b0;
        gap_left--;
      end else begin
        rsp_if.ready <= 1'b1;
        if ($urandom_range(0, 3) == 0) gap_left = draw_gap();
      end
    end
  end

  always @(posedge clk) begin : report_check
    out_item_t want;
    if (!rst && rsp_if.valid && rsp_if.ready) begin
      if (pending_reports.size() == 0) begin
        $error("cell report with no command outstanding");
        fails++;
      end else begin
        want = pending_reports.pop_front();
        check_field("pos_x", 9'(want.pos_x), 9'(rsp_if.data.pos_x));
        check_field("pos_y", 9'(want.pos_y), 9'(rsp_if.data.pos_y));
        check_field("cell_walls", 9'(want.cell_walls), 9'(rsp_if.data.cell_walls));
        check_field("cell_visited", 9'(want.cell_visited), 9'(rsp_if.data.cell_visited));
        check_field("moved", 9'(want.moved), 9'(rsp_if.data.moved));
        check_field("backtracked", 9'(want.backtracked), 9'(rsp_if.data.backtracked));
        check_field("finished", 9'(want.finished), 9'(rsp_if.data.finished));
        check_field("stack_depth", want.stack_depth, rsp_if.data.stack_depth);
        reports_checked++;
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", idle_cycles);
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst = 1'b1;
    req_if.valid = 1'b0;
    req_if.data = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data = '0;
    calm = 1'b0;
    long_hold_req = 1'b0;
    hold_active = 1'b0;
    idle_cycles = 0;
    reset_maze();
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_reset_state();
    test_side_extremes();
    test_backpressure();
    test_full_walks(900);
    test_noise(220);

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d commands over %0d walks, %0d mazes carved to the end, %0d side writes",
             items_sent, walks, mazes_done, side_writes);
    $display("%0d cell reports compared, %0d long receiver hold-offs", reports_checked,
             holds_done);
    if (fails == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
